### src/i2c_rf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register file package
// Shared sizes, codes and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package i2c_rf_pkg;

    localparam int BANK_COUNT    = 2;
    localparam int REGS_PER_BANK = 76;
    localparam int MEM_DEPTH     = BANK_COUNT * REGS_PER_BANK;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int PTR_W         = 7;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [7:0]       REG_LOW_LAST   = 8'h45;
    localparam logic [7:0]       REG_HIGH_FIRST = 8'hFA;
    localparam logic [PTR_W-1:0] REG_HIGH_ENTRY = 7'h46;

    localparam logic [1:0] NO_BANK = 2'd3;

    localparam logic [6:0] FIRST_ADDR_RESET  = 7'h40;
    localparam logic [6:0] SECOND_ADDR_RESET = 7'h60;
    localparam logic [7:0] WMASK_RESET       = 8'hFF;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_STOP  = 2'd3
    } act_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRST_ADDR  = 2'd0,
        CFG_SECOND_ADDR = 2'd1,
        CFG_WMASK       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

### src/i2c_multi_slave_register_file.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C multi-slave register file
// A result is registered when its event executes, after its capture; it waits
// while an earlier result is held. A new event is taken only after the last
// has executed; the register bank memory is read on capture ahead of each update.
// A finished result waits in the output register while the next event is taken.
// Reset clears all control state; bank entries read as zero until written.
// ----------------------------------------------------------------------------
module i2c_multi_slave_register_file
    import i2c_rf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             action,
    input  wire logic [7:0]             bus_byte,
    input  wire logic                   master_nak,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        ack_drive,
    output logic                        send_valid,
    output logic [7:0]                  send_byte,
    output logic                        busy_res,
    output logic                        write_done,
    output logic                        written_bank,
    output logic [7:0]                  written_count
);

    ctrl_cmd_t cmd;

    i2c_rf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    i2c_rf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .bus_byte      (bus_byte),
        .master_nak    (master_nak),
        .ack_drive     (ack_drive),
        .send_valid    (send_valid),
        .send_byte     (send_byte),
        .busy_res      (busy_res),
        .write_done    (write_done),
        .written_bank  (written_bank),
        .written_count (written_count)
    );

    // Only one event is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("event accepted while another was in flight");

    // A stop always leaves the bus phase idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_done) |-> !busy_res)
        else $error("write report while still busy");

    // A transmitted beat comes from an acknowledge slot only.
    a_send_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_valid) |-> (!ack_drive && !write_done))
        else $error("send beat mixed with other responses");

    // A count is reported only together with the done flag.
    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (written_count != 8'd0 || written_bank)) |-> write_done)
        else $error("write count without done flag");

endmodule
`default_nettype wire

### src/i2c_rf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register file controller
// Sequences capture and execution of one bus event and owns the result valid.
// ----------------------------------------------------------------------------
module i2c_rf_ctrl
    import i2c_rf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_WAIT = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### src/i2c_rf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register file datapath
// Bus phase, bank select, pointer, write counts, register banks and results.
// ----------------------------------------------------------------------------
module i2c_rf_datapath
    import i2c_rf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctrl_cmd_t              cmd,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [1:0]             action,
    input  wire logic [7:0]             bus_byte,
    input  wire logic                   master_nak,
    output logic                        ack_drive,
    output logic                        send_valid,
    output logic [7:0]                  send_byte,
    output logic                        busy_res,
    output logic                        write_done,
    output logic                        written_bank,
    output logic [7:0]                  written_count
);

    typedef enum logic [4:0] {
        PH_ADDR  = 5'b00001,
        PH_REG   = 5'b00010,
        PH_READ  = 5'b00100,
        PH_WRITE = 5'b01000,
        PH_IDLE  = 5'b10000
    } phase_t;

    logic [6:0]       first_addr_reg;
    logic [6:0]       second_addr_reg;
    logic [7:0]       wmask_reg;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [1:0]       bank_reg;
    logic [1:0]       bank_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [7:0]       count_reg [BANK_COUNT];
    logic [7:0]       count_next [BANK_COUNT];

    logic [7:0]       mem_reg [MEM_DEPTH];
    logic             entry_valid_reg [MEM_DEPTH];
    logic [7:0]       mem_q_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_now;

    act_t             act_reg;
    logic [7:0]       byte_reg;
    logic             nak_reg;

    logic             mem_we;
    logic [7:0]       mem_wdata;
    logic [7:0]       old_byte;
    logic             bank_ok;
    logic [6:0]       bus_addr;
    logic [1:0]       found;
    logic [PTR_W-1:0] ptr_adv;

    logic             ack_next;
    logic             svalid_next;
    logic [7:0]       sbyte_next;
    logic             wdone_next;
    logic             wbank_next;
    logic [7:0]       wcount_next;

    logic             ack_drive_reg;
    logic             send_valid_reg;
    logic [7:0]       send_byte_reg;
    logic             busy_res_reg;
    logic             write_done_reg;
    logic             written_bank_reg;
    logic [7:0]       written_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_addr_reg  <= FIRST_ADDR_RESET;
            second_addr_reg <= SECOND_ADDR_RESET;
            wmask_reg       <= WMASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FIRST_ADDR:  first_addr_reg  <= cfg_data[6:0];
                CFG_SECOND_ADDR: second_addr_reg <= cfg_data[6:0];
                CFG_WMASK:       wmask_reg       <= cfg_data;
                default:         wmask_reg       <= wmask_reg;
            endcase
        end
    end

    assign addr_now = bank_reg[0] ? ADDR_W'(REGS_PER_BANK) + ADDR_W'(ptr_reg)
                                  : ADDR_W'(ptr_reg);
    assign bank_ok  = (bank_reg < 2'(BANK_COUNT));
    assign old_byte = entry_valid_reg[addr_reg] ? mem_q_reg : 8'd0;
    assign bus_addr = byte_reg[7:1];
    assign ptr_adv  = (ptr_reg == PTR_W'(REGS_PER_BANK - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        if (bus_addr == first_addr_reg)
        begin
            found = 2'd0;
        end
        else if (BANK_COUNT > 1 && bus_addr == second_addr_reg)
        begin
            found = 2'd1;
        end
        else
        begin
            found = NO_BANK;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bank_next   = bank_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_wdata   = (old_byte & ~wmask_reg) | (byte_reg & wmask_reg);
        ack_next    = 1'b0;
        svalid_next = 1'b0;
        sbyte_next  = 8'd0;
        wdone_next  = 1'b0;
        wbank_next  = 1'b0;
        wcount_next = 8'd0;
        if (cmd.execute)
        begin
            case (act_reg)
                ACT_START:
                begin
                    phase_next = PH_ADDR;
                end
                ACT_BYTE:
                begin
                    case (phase_reg)
                        PH_ADDR:
                        begin
                            bank_next = found;
                            if (bus_addr == 7'd0 || found == NO_BANK)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                ack_next = 1'b1;
                                if (byte_reg[0])
                                begin
                                    phase_next = PH_READ;
                                end
                                else
                                begin
                                    ptr_next             = '0;
                                    phase_next           = PH_REG;
                                    count_next[found[0]] = 8'd1;
                                end
                            end
                        end
                        PH_REG:
                        begin
                            if (byte_reg <= REG_LOW_LAST)
                            begin
                                ptr_next   = byte_reg[PTR_W-1:0];
                                phase_next = PH_WRITE;
                                ack_next   = 1'b1;
                            end
                            else if (byte_reg >= REG_HIGH_FIRST)
                            begin
                                ptr_next   = PTR_W'(byte_reg - REG_HIGH_FIRST) + REG_HIGH_ENTRY;
                                phase_next = PH_WRITE;
                                ack_next   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_WRITE:
                        begin
                            if (bank_ok)
                            begin
                                mem_we                  = 1'b1;
                                count_next[bank_reg[0]] = count_reg[bank_reg[0]] + 8'd1;
                            end
                            ptr_next = ptr_adv;
                            ack_next = 1'b1;
                        end
                        default:
                        begin
                            ack_next = 1'b0;
                        end
                    endcase
                end
                ACT_ACK:
                begin
                    if (phase_reg == PH_READ)
                    begin
                        if (nak_reg)
                        begin
                            ptr_next   = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            svalid_next = 1'b1;
                            sbyte_next  = bank_ok ? old_byte : 8'd0;
                            ptr_next    = ptr_adv;
                        end
                    end
                end
                default:
                begin
                    if (phase_reg == PH_WRITE && bank_ok && count_reg[bank_reg[0]] != 8'd0)
                    begin
                        wdone_next              = 1'b1;
                        wbank_next              = bank_reg[0];
                        wcount_next             = count_reg[bank_reg[0]];
                        count_next[bank_reg[0]] = 8'd0;
                    end
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ADDR;
            bank_reg  <= NO_BANK;
            ptr_reg   <= '0;
            for (int i = 0; i < BANK_COUNT; i++)
            begin
                count_reg[i] <= 8'd0;
            end
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            bank_reg   <= bank_next;
            ptr_reg    <= ptr_next;
            count_reg  <= count_next;
            if (mem_we)
            begin
                entry_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= act_t'(action);
            byte_reg  <= bus_byte;
            nak_reg   <= master_nak;
            addr_reg  <= addr_now;
            mem_q_reg <= mem_reg[addr_now];
        end
        if (mem_we)
        begin
            mem_reg[addr_reg] <= mem_wdata;
        end
        if (cmd.execute)
        begin
            ack_drive_reg     <= ack_next;
            send_valid_reg    <= svalid_next;
            send_byte_reg     <= sbyte_next;
            busy_res_reg      <= (phase_next == PH_REG) || (phase_next == PH_READ) ||
                                 (phase_next == PH_WRITE);
            write_done_reg    <= wdone_next;
            written_bank_reg  <= wbank_next;
            written_count_reg <= wcount_next;
        end
    end

    assign ack_drive     = ack_drive_reg;
    assign send_valid    = send_valid_reg;
    assign send_byte     = send_byte_reg;
    assign busy_res      = busy_res_reg;
    assign write_done    = write_done_reg;
    assign written_bank  = written_bank_reg;
    assign written_count = written_count_reg;

endmodule
`default_nettype wire
